@@ hw/rtl/tsqm_pkg.sv @@
// Shared constants, types and codes for the touch sample qualifier and mapper.
package tsqm_pkg;

  localparam int RAW_W       = 12;
  localparam int ORIENT_W    = 3;
  localparam int REASON_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = 2 * RAW_W;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STAGES  = PROD_W / DIV_BITS;
  // Average stage, product stage, divider stages and the clamp register.
  localparam int LANE_DEPTH  = DIV_STAGES + 3;

  localparam logic [RAW_W-1:0] JITTER_LIMIT = RAW_W'(50);

  localparam logic [RAW_W-1:0]    RST_RAW_LOW  = RAW_W'(200);
  localparam logic [RAW_W-1:0]    RST_RAW_HIGH = RAW_W'(3900);
  localparam logic [RAW_W-1:0]    RST_WIDTH    = RAW_W'(320);
  localparam logic [RAW_W-1:0]    RST_HEIGHT   = RAW_W'(240);
  localparam logic [ORIENT_W-1:0] RST_ORIENT   = '0;

  localparam int ORIENT_SWAP  = 0;
  localparam int ORIENT_INV_X = 1;
  localparam int ORIENT_INV_Y = 2;

  typedef enum logic [REASON_W-1:0] {
    RSN_OK        = 3'd0,
    RSN_PEN_UP    = 3'd1,
    RSN_FAULT     = 3'd2,
    RSN_JITTER    = 3'd3,
    RSN_BELOW_MIN = 3'd4
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOW  = 3'd0,
    CFG_X_HIGH = 3'd1,
    CFG_Y_LOW  = 3'd2,
    CFG_Y_HIGH = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5,
    CFG_ORIENT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0]  rem;
    logic [PROD_W-1:0] nq;
  } div_state_t;

  typedef struct packed {
    logic [RAW_W-1:0] pos;
    logic             jitter;
    logic             below;
  } lane_res_t;

  typedef struct packed {
    logic valid;
    logic pen_up;
    logic fault;
  } side_t;

  typedef struct packed {
    logic             touched;
    logic [RAW_W-1:0] x_pos;
    logic [RAW_W-1:0] y_pos;
    reason_t          reason;
  } out_item_t;

endpackage

@@ hw/rtl/tsqm_ifs.sv @@
// Handshake interfaces for the sample, result and register write channels.
interface tsqm_in_if import tsqm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] x_first;
  logic [RAW_W-1:0] y_first;
  logic [RAW_W-1:0] x_second;
  logic [RAW_W-1:0] y_second;
  logic             pen_up;
  logic             sample_fault;

  modport source (output valid, x_first, y_first, x_second, y_second, pen_up, sample_fault,
                  input ready);
  modport sink (input valid, x_first, y_first, x_second, y_second, pen_up, sample_fault,
                output ready);
endinterface

interface tsqm_out_if import tsqm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                touched;
  logic [RAW_W-1:0]    x_pos;
  logic [RAW_W-1:0]    y_pos;
  logic [REASON_W-1:0] reject_reason;

  modport source (output valid, touched, x_pos, y_pos, reject_reason, input ready);
  modport sink (input valid, touched, x_pos, y_pos, reject_reason, output ready);
endinterface

interface tsqm_cfg_if import tsqm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RAW_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tsqm_div_stage.sv @@
// One pipeline stage of the restoring divider, retiring two quotient bits.
module tsqm_div_stage import tsqm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [RAW_W-1:0] divisor,
  input  div_state_t       st_in,
  output div_state_t       st_out
);

  div_state_t st_nxt;

  // The shift register holds the dividend bits not yet used on top and the
  // quotient bits found so far at the bottom.
  always_comb begin
    logic [RAW_W:0] trial;
    logic           ge;
    st_nxt = st_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial      = {st_nxt.rem, st_nxt.nq[PROD_W-1]};
      ge         = (trial >= {1'b0, divisor});
      st_nxt.nq  = {st_nxt.nq[PROD_W-2:0], ge};
      st_nxt.rem = ge ? RAW_W'(trial - {1'b0, divisor}) : trial[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_nxt;
    end
  end

endmodule

@@ hw/rtl/tsqm_lane.sv @@
// One axis lane: averaging, qualification, scaling, pipelined division and clamping.
module tsqm_lane import tsqm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [RAW_W-1:0] first,
  input  logic [RAW_W-1:0] second,
  input  logic [RAW_W-1:0] raw_low,
  input  logic [RAW_W-1:0] raw_high,
  input  logic [RAW_W-1:0] size,
  output lane_res_t        res
);

  logic [RAW_W:0]   sum;
  logic [RAW_W:0]   diff;
  logic [RAW_W:0]   adiff;
  logic [RAW_W-1:0] avg;
  logic             jitter;
  logic             below;

  logic [RAW_W-1:0]  ofs_r;
  logic [PROD_W-1:0] prod_r;
  logic              jit_r [LANE_DEPTH-1];
  logic              below_r [LANE_DEPTH-1];

  div_state_t        st [DIV_STAGES+1];

  logic [RAW_W:0]   span;
  logic             span_pos;
  logic [RAW_W-1:0] top;
  logic [PROD_W-1:0] quo;
  logic [RAW_W-1:0] pos;

  assign sum    = {1'b0, first} + {1'b0, second};
  assign avg    = sum[RAW_W:1];
  assign diff   = {1'b0, first} - {1'b0, second};
  assign adiff  = diff[RAW_W] ? (~diff + 1'b1) : diff;
  assign jitter = (adiff > {1'b0, JITTER_LIMIT});
  assign below  = (avg < raw_low);

  always_ff @(posedge clk) begin
    if (en) begin
      ofs_r      <= avg - raw_low;
      jit_r[0]   <= jitter;
      below_r[0] <= below;
      prod_r     <= {{RAW_W{1'b0}}, ofs_r} * {{RAW_W{1'b0}}, size};
      for (int k = 1; k < LANE_DEPTH - 1; k++) begin
        jit_r[k]   <= jit_r[k-1];
        below_r[k] <= below_r[k-1];
      end
    end
  end

  assign span     = {1'b0, raw_high} - {1'b0, raw_low};
  assign span_pos = !span[RAW_W] && (span != '0);

  assign st[0] = '{rem: '0, nq: prod_r};

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tsqm_div_stage u_stage (
      .clk     (clk),
      .en      (en),
      .divisor (span[RAW_W-1:0]),
      .st_in   (st[g]),
      .st_out  (st[g+1])
    );
  end

  // A negative or zero span always maps to pixel zero.
  assign quo = st[DIV_STAGES].nq;
  assign top = (size == '0) ? '0 : size - 1'b1;
  assign pos = !span_pos ? '0 :
               (quo > {{RAW_W{1'b0}}, top}) ? top : quo[RAW_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      res.pos    <= pos;
      res.jitter <= jit_r[LANE_DEPTH-2];
      res.below  <= below_r[LANE_DEPTH-2];
    end
  end

endmodule

@@ hw/rtl/tsqm_merge.sv @@
// Combines both lanes into one result item and holds it in an output register with a skid stage.
module tsqm_merge import tsqm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  side_t               side,
  input  lane_res_t           lane_x,
  input  lane_res_t           lane_y,
  input  logic [ORIENT_W-1:0] orient,
  input  logic [RAW_W-1:0]    width,
  input  logic [RAW_W-1:0]    height,
  output logic                skid_full,
  tsqm_out_if.source          out_ch
);

  out_item_t        item;
  logic [RAW_W-1:0] top_w;
  logic [RAW_W-1:0] top_h;
  logic [RAW_W-1:0] px;
  logic [RAW_W-1:0] py;

  out_item_t out_r;
  out_item_t skid_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      out_fire;

  assign top_w = (width == '0) ? '0 : width - 1'b1;
  assign top_h = (height == '0) ? '0 : height - 1'b1;

  assign px = orient[ORIENT_SWAP] ? lane_y.pos : lane_x.pos;
  assign py = orient[ORIENT_SWAP] ? lane_x.pos : lane_y.pos;

  always_comb begin
    item = '0;
    priority if (side.pen_up) begin
      item.reason = RSN_PEN_UP;
    end else if (side.fault) begin
      item.reason = RSN_FAULT;
    end else if (lane_x.jitter || lane_y.jitter) begin
      item.reason = RSN_JITTER;
    end else if (lane_x.below || lane_y.below) begin
      item.reason = RSN_BELOW_MIN;
    end else begin
      item.reason  = RSN_OK;
      item.touched = 1'b1;
      item.x_pos   = orient[ORIENT_INV_X] ? top_w - px : px;
      item.y_pos   = orient[ORIENT_INV_Y] ? top_h - py : py;
    end
  end

  assign out_fire  = out_valid_r && out_ch.ready;
  assign skid_full = skid_valid_r;

  // While the skid stage is full the pipeline is frozen, so no new item arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (side.valid) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (side.valid) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= item;
      end else begin
        out_r <= item;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.touched       = out_r.touched;
  assign out_ch.x_pos         = out_r.x_pos;
  assign out_ch.y_pos         = out_r.y_pos;
  assign out_ch.reject_reason = out_r.reason;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output register is empty");

  a_touch_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.touched == (out_r.reason == RSN_OK)))
    else $error("touched flag disagrees with reject reason");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.touched) |-> (out_r.x_pos == '0 && out_r.y_pos == '0))
    else $error("rejected item carries a nonzero position");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_fire) |=> (out_valid_r && !skid_valid_r))
    else $error("skid item lost when the output register was taken");

endmodule

@@ hw/rtl/touch_sample_qualify_and_map.sv @@
// Top level of the touch sample qualifier and panel mapper.
// Usage:
//   in_ch carries one item of two X/Y conversion pairs plus pen-up and fault
//   flags; it is taken at a clock edge where valid and ready are both high.
//   out_ch gives exactly one result item per input item, in order: touched,
//   panel X/Y pixel and a reject reason.
//   cfg_ch writes the seven calibration and panel registers by index; it is
//   always ready, and writes are expected only while no item is in flight.
//   Each axis runs in its own lane: average and qualify, scale by the panel
//   size, then a divider pipeline of twelve stages at two quotient bits each,
//   then a clamp register. A merge stage picks the reject reason and applies
//   axis swap and inversion into the output register.
//   One item is taken every cycle while the skid stage is not full.
//   When the receiver stalls, one finished item waits in the output register
//   and one more in a skid stage; once the skid stage is full the whole
//   pipeline freezes and in_ch.ready drops until the output is taken.
//   Synchronous reset empties the pipeline and loads the register defaults.
module touch_sample_qualify_and_map import tsqm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tsqm_in_if.sink    in_ch,
  tsqm_out_if.source out_ch,
  tsqm_cfg_if.sink   cfg_ch
);

  logic [RAW_W-1:0]    raw_x_low_r;
  logic [RAW_W-1:0]    raw_x_high_r;
  logic [RAW_W-1:0]    raw_y_low_r;
  logic [RAW_W-1:0]    raw_y_high_r;
  logic [RAW_W-1:0]    width_r;
  logic [RAW_W-1:0]    height_r;
  logic [ORIENT_W-1:0] orient_r;

  logic             advance;
  logic             skid_full;
  side_t            side_r [LANE_DEPTH];
  logic [RAW_W-1:0] size_x;
  logic [RAW_W-1:0] size_y;
  lane_res_t        res_x;
  lane_res_t        res_y;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_x_low_r  <= RST_RAW_LOW;
      raw_x_high_r <= RST_RAW_HIGH;
      raw_y_low_r  <= RST_RAW_LOW;
      raw_y_high_r <= RST_RAW_HIGH;
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      orient_r     <= RST_ORIENT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_X_LOW:  raw_x_low_r  <= cfg_ch.data;
        CFG_X_HIGH: raw_x_high_r <= cfg_ch.data;
        CFG_Y_LOW:  raw_y_low_r  <= cfg_ch.data;
        CFG_Y_HIGH: raw_y_high_r <= cfg_ch.data;
        CFG_WIDTH:  width_r      <= cfg_ch.data;
        CFG_HEIGHT: height_r     <= cfg_ch.data;
        CFG_ORIENT: orient_r     <= cfg_ch.data[ORIENT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !skid_full;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_DEPTH; k++) begin
        side_r[k] <= '0;
      end
    end else if (advance) begin
      side_r[0] <= '{valid: in_ch.valid, pen_up: in_ch.pen_up, fault: in_ch.sample_fault};
      for (int k = 1; k < LANE_DEPTH; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // With swapped axes each lane scales to the other panel dimension.
  assign size_x = orient_r[ORIENT_SWAP] ? height_r : width_r;
  assign size_y = orient_r[ORIENT_SWAP] ? width_r : height_r;

  tsqm_lane u_lane_x (
    .clk      (clk),
    .en       (advance),
    .first    (in_ch.x_first),
    .second   (in_ch.x_second),
    .raw_low  (raw_x_low_r),
    .raw_high (raw_x_high_r),
    .size     (size_x),
    .res      (res_x)
  );

  tsqm_lane u_lane_y (
    .clk      (clk),
    .en       (advance),
    .first    (in_ch.y_first),
    .second   (in_ch.y_second),
    .raw_low  (raw_y_low_r),
    .raw_high (raw_y_high_r),
    .size     (size_y),
    .res      (res_y)
  );

  tsqm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .side      (side_r[LANE_DEPTH-1] & {advance, 2'b11}),
    .lane_x    (res_x),
    .lane_y    (res_y),
    .orient    (orient_r),
    .width     (width_r),
    .height    (height_r),
    .skid_full (skid_full),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/sv/touch_map_checker.sv @@
// Checker for the touch qualifier: watches all three channels, predicts each result and compares.
module touch_map_checker import tsqm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tsqm_in_if   in_mon,
  tsqm_out_if  out_mon,
  tsqm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_results
);

  // Calibration and panel registers as the block should hold them.
  logic [RAW_W-1:0]    x_low, x_high, y_low, y_high, width, height;
  logic [ORIENT_W-1:0] orient;

  out_item_t touch_q[$];
  int        errors = 0;

  function automatic int eff_size(int size);
    return (size == 0) ? 1 : size;
  endfunction

  function automatic int raw_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Maps one averaged reading onto pixels; signed division truncates toward zero.
  function automatic int scale_axis(int avg, int lo, int hi, int size);
    int span, top, q;
    span = hi - lo;
    top  = eff_size(size) - 1;
    if (span == 0) return 0;
    q = ((avg - lo) * size) / span;
    if (q < 0) q = 0;
    if (q > top) q = top;
    return q;
  endfunction

  function automatic out_item_t predict_touch(int x1, int y1, int x2, int y2,
                                              logic pen, logic fault);
    out_item_t r;
    int        ax, ay, px, py;
    r = '0;
    if (pen) r.reason = RSN_PEN_UP;
    else if (fault) r.reason = RSN_FAULT;
    else if (raw_gap(x1, x2) > int'(JITTER_LIMIT) || raw_gap(y1, y2) > int'(JITTER_LIMIT))
      r.reason = RSN_JITTER;
    if (r.reason != RSN_OK) return r;
    ax = (x1 + x2) >> 1;
    ay = (y1 + y2) >> 1;
    if (ax < int'(x_low) || ay < int'(y_low)) begin
      r.reason = RSN_BELOW_MIN;
      return r;
    end
    if (orient[ORIENT_SWAP]) begin
      px = scale_axis(ay, y_low, y_high, width);
      py = scale_axis(ax, x_low, x_high, height);
    end else begin
      px = scale_axis(ax, x_low, x_high, width);
      py = scale_axis(ay, y_low, y_high, height);
    end
    if (orient[ORIENT_INV_X]) px = eff_size(width) - 1 - px;
    if (orient[ORIENT_INV_Y]) py = eff_size(height) - 1 - py;
    r.touched = 1'b1;
    r.x_pos   = px[RAW_W-1:0];
    r.y_pos   = py[RAW_W-1:0];
    return r;
  endfunction

  function automatic int check_field(string name, int want, int got);
    if (want == got) return 0;
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      x_low  <= RST_RAW_LOW;
      x_high <= RST_RAW_HIGH;
      y_low  <= RST_RAW_LOW;
      y_high <= RST_RAW_HIGH;
      width  <= RST_WIDTH;
      height <= RST_HEIGHT;
      orient <= RST_ORIENT;
      touch_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        touch_q.push_back(predict_touch(in_mon.x_first, in_mon.y_first, in_mon.x_second,
                                        in_mon.y_second, in_mon.pen_up,
                                        in_mon.sample_fault));
      if (out_mon.valid && out_mon.ready) begin
        if (touch_q.size() == 0) begin
          $error("result item arrived with no sample outstanding");
          errors++;
        end else begin
          want = touch_q.pop_front();
          errors += check_field("touched", want.touched, out_mon.touched);
          errors += check_field("x_pos", want.x_pos, out_mon.x_pos);
          errors += check_field("y_pos", want.y_pos, out_mon.y_pos);
          errors += check_field("reject_reason", want.reason, out_mon.reject_reason);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_X_LOW:  x_low  <= cfg_mon.data;
          CFG_X_HIGH: x_high <= cfg_mon.data;
          CFG_Y_LOW:  y_low  <= cfg_mon.data;
          CFG_Y_HIGH: y_high <= cfg_mon.data;
          CFG_WIDTH:  width  <= cfg_mon.data;
          CFG_HEIGHT: height <= cfg_mon.data;
          CFG_ORIENT: orient <= cfg_mon.data[ORIENT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_results <= touch_q.size();
    fail_count      <= errors;
  end

endmodule

@@ tb/sv/tb.sv @@
// Top of the touch qualifier testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;
  import tsqm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_results;

  tsqm_in_if  in_ch();
  tsqm_out_if out_ch();
  tsqm_cfg_if cfg_ch();

  touch_sample_qualify_and_map u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  touch_map_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);

  // Valid is left high after an accept so that the next item never lowers and
  // raises it within one step; idle cycles and the drain lower it.
  task automatic put_sample(int x1, int y1, int x2, int y2, logic pen, logic fault);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.x_first      <= x1[RAW_W-1:0];
    in_ch.y_first      <= y1[RAW_W-1:0];
    in_ch.x_second     <= x2[RAW_W-1:0];
    in_ch.y_second     <= y2[RAW_W-1:0];
    in_ch.pen_up       <= pen;
    in_ch.sample_fault <= fault;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic probe(int x1, int y1, int x2, int y2, logic pen, logic fault);
    put_sample(x1, y1, x2, y2, pen, fault);
    drain_results();
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [RAW_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_calibration(int xl, int xh, int yl, int yh, int wd, int ht, int ori);
    write_reg(CFG_X_LOW, xl[RAW_W-1:0]);
    write_reg(CFG_X_HIGH, xh[RAW_W-1:0]);
    write_reg(CFG_Y_LOW, yl[RAW_W-1:0]);
    write_reg(CFG_Y_HIGH, yh[RAW_W-1:0]);
    write_reg(CFG_WIDTH, wd[RAW_W-1:0]);
    write_reg(CFG_HEIGHT, ht[RAW_W-1:0]);
    write_reg(CFG_ORIENT, ori[RAW_W-1:0]);
    cfg_ch.valid <= 1'b0;
  endtask

  // Second reading close to the first; now and then just past the jitter window.
  function automatic int near_reading(int base);
    int d;
    d = ($urandom_range(0, 9) == 0) ? $urandom_range(45, 60) : $urandom_range(0, 50);
    if ($urandom_range(0, 1) != 0) return (base + d <= 4095) ? base + d : base - d;
    return (base - d >= 0) ? base - d : base + d;
  endfunction

  task automatic random_sample();
    int x1, y1;
    x1 = $urandom_range(0, 4095);
    y1 = $urandom_range(0, 4095);
    if ($urandom_range(0, 99) < 80)
      put_sample(x1, y1, near_reading(x1), near_reading(y1), 1'b0, 1'b0);
    else
      put_sample(x1, y1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_idle_pct        = 0;
    out_stall_pct      <= 0;
    in_ch.valid        <= 1'b0;
    in_ch.x_first      <= '0;
    in_ch.y_first      <= '0;
    in_ch.x_second     <= '0;
    in_ch.y_second     <= '0;
    in_ch.pen_up       <= 1'b0;
    in_ch.sample_fault <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_X_LOW;
    cfg_ch.data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset calibration, each drained before the next.
    probe(100, 100, 500, 500, 1'b1, 1'b1);
    probe(1000, 1000, 1200, 1000, 1'b0, 1'b1);
    probe(1000, 1000, 1051, 1000, 1'b0, 1'b0);
    probe(1000, 1000, 1000, 949, 1'b0, 1'b0);
    probe(1000, 2000, 1050, 1950, 1'b0, 1'b0);
    probe(199, 1000, 199, 1000, 1'b0, 1'b0);
    probe(1000, 198, 1000, 201, 1'b0, 1'b0);
    probe(200, 200, 201, 201, 1'b0, 1'b0);
    probe(4095, 4095, 4095, 4095, 1'b0, 1'b0);
    probe(0, 0, 0, 0, 1'b0, 1'b0);
    probe(4095, 0, 4045, 0, 1'b0, 1'b0);
    probe(3900, 3900, 3899, 3899, 1'b0, 1'b0);
    // High below low, zero height, width of one, axes swapped.
    set_calibration(3000, 1000, 2500, 500, 1, 0, 1);
    probe(3500, 3000, 3500, 3000, 1'b0, 1'b0);
    probe(4095, 4095, 4095, 4095, 1'b0, 1'b0);
    // Flat X span, zero width, both axes inverted.
    set_calibration(1000, 1000, 0, 4095, 0, 4095, 6);
    probe(2000, 2000, 2000, 2000, 1'b0, 1'b0);
    probe(0, 4095, 0, 4095, 1'b0, 1'b0);
    // Full-scale calibration and panel with every orientation bit set.
    set_calibration(0, 4095, 0, 4095, 4095, 4095, 7);
    probe(4095, 4095, 4095, 4095, 1'b0, 1'b0);
    probe(0, 0, 0, 0, 1'b0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: set_calibration(200, 3900, 200, 3900, 320, 240, 0);
        1: set_calibration(0, 4095, 0, 4095, 4095, 4095, 7);
        2: set_calibration(3000, 1000, 2500, 500, 1, 0, 1);
        3: set_calibration(1000, 1000, 4095, 0, 0, 1, 6);
        default: begin
          if (ph % 3 == 0)
            set_calibration($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 7));
          else
            set_calibration($urandom_range(0, 1500), $urandom_range(2500, 4095),
                            $urandom_range(0, 1500), $urandom_range(2500, 4095),
                            $urandom_range(1, 800), $urandom_range(1, 800),
                            $urandom_range(0, 7));
        end
      endcase
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
        1: begin in_idle_pct = 48; out_stall_pct <= 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct <= 48; end
        default: begin in_idle_pct = 31; out_stall_pct <= 31; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_sample();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
